>>> rtl/sha1bs_pkg.sv
// Shared types and constants of the SHA-1 byte-stream hash.
// Used by sha1bs_core and sha1_byte_stream_hash_top; depends on nothing else.
package sha1bs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Five 32-bit words, index 0 is the most significant digest word.
    typedef logic [0:4][31:0] t_chain;

    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       start;
        logic       reinit;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    localparam t_chain SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                  32'h10325476, 32'hC3D2E1F0};

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [6:0] NUM_ROUNDS    = 7'd80;
    localparam logic [6:0] SCHED_WORDS   = 7'd16;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] BLOCK_END_POS = 6'd63;

endpackage

>>> rtl/sha1bs_core.sv
// SHA-1 compression core: 512-bit byte-loaded block/schedule register,
// one shared round unit used 80 times per block, and the chaining value.
// Depends on sha1bs_pkg.
module sha1bs_core
    import sha1bs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    output t_core_sts o_sts,
    output t_chain    o_chain
);

    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic        r_busy;
    logic [6:0]  r_round;
    t_chain      r_chain;

    logic [31:0] w_cur;
    logic [31:0] w_f;
    logic [31:0] w_k;
    logic [31:0] w_t;
    logic        w_run;

    assign w_run = r_busy && (r_round != NUM_ROUNDS);

    // The schedule rotates through the first 16 rounds, so the window holds
    // W[t-16..t-1] in order when the expansion starts.
    always_comb begin
        if (r_round < SCHED_WORDS) begin
            w_cur = r_w[0];
        end else begin
            w_cur = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
            w_cur = {w_cur[30:0], w_cur[31]};
        end
    end

    always_comb begin
        if (r_round inside {[7'd0:7'd19]}) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_R0;
        end else if (r_round inside {[7'd20:7'd39]}) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R1;
        end else if (r_round inside {[7'd40:7'd59]}) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_R2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_R3;
        end
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_cur;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            // Bytes enter at the low end; the block reads big-endian when full.
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_ctl.shift_byte};
        end else if (w_run) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (w_run) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_chain <= SHA1_IV;
        end else begin
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                if (r_round == NUM_ROUNDS) begin
                    r_busy     <= 1'b0;
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_chain[4] <= r_chain[4] + r_e;
                end else begin
                    r_round <= r_round + 7'd1;
                end
            end
            if (i_ctl.reinit) begin
                r_chain <= SHA1_IV;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_round == NUM_ROUNDS);
    assign o_chain    = r_chain;

endmodule

>>> rtl/sha1_byte_stream_hash_top.sv
// SHA-1 byte-stream hash, top level: request handshakes, padding sequencer,
// bit-length counter and digest output buffer. Depends on sha1bs_pkg, sha1bs_core.
//
// A message byte is taken in the idle state and the next request is taken in the
// following cycle, except that the 64th byte of each block starts a compression
// that holds off input until it is done: 80 rounds through the single round unit
// and a fold of the result into the chaining value. The last request appends
// the padding (0x80, zeros up to byte 56, then the eight length bytes) one byte
// per cycle, pausing while a full block is compressed; the padding takes one
// compression, or two when 56 or more message bytes follow the last full block.
// The five digest words then leave from an output buffer, first word first, while
// new message bytes are already being taken; the next digest waits for that
// buffer to empty.
module sha1_byte_stream_hash_top
    import sha1bs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_COMP  = 2'd1;
    localparam logic [1:0] S_PAD   = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;

    logic [1:0]  r_state,   n_state;
    logic [1:0]  r_after,   n_after;
    logic [1:0]  r_pad_ph,  n_pad_ph;
    logic [5:0]  r_pos,     n_pos;
    logic [63:0] r_bits,    n_bits;
    logic [63:0] r_len,     n_len;
    t_chain      r_dig,     n_dig;
    logic [2:0]  r_out_idx, n_out_idx;
    logic        r_out_act, n_out_act;

    t_core_ctl w_ctl;
    t_core_sts w_sts;
    t_chain    w_chain;
    logic      w_in_acc;
    logic      w_out_acc;
    logic [5:0] w_pos_inc;

    sha1bs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_chain (w_chain)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_act && !i_out_stall;
    assign w_pos_inc  = r_pos + 6'd1;

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_pad_ph  = r_pad_ph;
        n_pos     = r_pos;
        n_bits    = r_bits;
        n_len     = r_len;
        n_dig     = r_dig;
        n_out_idx = r_out_idx;
        n_out_act = r_out_act;
        w_ctl     = '0;

        if (w_out_acc) begin
            n_dig = {r_dig[1:4], 32'h0};
            if (r_out_idx == LAST_WORD_IDX) begin
                n_out_act = 1'b0;
            end else begin
                n_out_idx = r_out_idx + 3'd1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.has_byte) begin
                        w_ctl.shift_en   = 1'b1;
                        w_ctl.shift_byte = i_in_data.data_byte;
                        n_pos            = w_pos_inc;
                        n_bits           = r_bits + 64'd8;
                    end
                    if (i_in_data.last_item) begin
                        n_pad_ph = PH_MARK;
                        n_len    = i_in_data.has_byte ? (r_bits + 64'd8) : r_bits;
                        n_state  = S_PAD;
                    end
                    if (i_in_data.has_byte && (r_pos == BLOCK_END_POS)) begin
                        w_ctl.start = 1'b1;
                        n_after     = i_in_data.last_item ? S_PAD : S_IDLE;
                        n_state     = S_COMP;
                    end
                end
            end
            S_COMP: begin
                if (w_sts.done) begin
                    n_state = r_after;
                end
            end
            S_PAD: begin
                w_ctl.shift_en = 1'b1;
                n_pos          = w_pos_inc;
                case (r_pad_ph)
                    PH_MARK: w_ctl.shift_byte = PAD_MARK;
                    PH_LEN:  w_ctl.shift_byte = r_len[63:56];
                    default: w_ctl.shift_byte = 8'h00;
                endcase
                if (r_pad_ph == PH_LEN) begin
                    n_len = {r_len[55:0], 8'h00};
                end else if (w_pos_inc == LEN_POS) begin
                    n_pad_ph = PH_LEN;
                end else begin
                    n_pad_ph = PH_ZERO;
                end
                if (r_pos == BLOCK_END_POS) begin
                    w_ctl.start = 1'b1;
                    n_after     = (r_pad_ph == PH_LEN) ? S_FINAL : S_PAD;
                    n_state     = S_COMP;
                end
            end
            S_FINAL: begin
                if (!r_out_act) begin
                    n_dig        = w_chain;
                    n_out_idx    = '0;
                    n_out_act    = 1'b1;
                    w_ctl.reinit = 1'b1;
                    n_pos        = '0;
                    n_bits       = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= S_IDLE;
            r_pad_ph  <= PH_MARK;
            r_pos     <= '0;
            r_bits    <= '0;
            r_out_idx <= '0;
            r_out_act <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_pad_ph  <= n_pad_ph;
            r_pos     <= n_pos;
            r_bits    <= n_bits;
            r_out_idx <= n_out_idx;
            r_out_act <= n_out_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_dig <= n_dig;
    end

    assign o_out_valid            = r_out_act;
    assign o_out_data.digest_word = r_dig[0];
    assign o_out_data.word_index  = r_out_idx;
    assign o_out_data.last_word   = (r_out_idx == LAST_WORD_IDX);

    a_done_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_COMP))
        else $error("compression finished outside the compress state");

    a_idle_core_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_sts.busy)
        else $error("round unit busy while requests are taken");

    a_len_phase_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PAD) && (r_pad_ph == PH_LEN)) |-> (r_pos >= LEN_POS))
        else $error("length bytes placed before byte 56 of the block");

    a_out_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_act |-> (r_out_idx <= LAST_WORD_IDX))
        else $error("digest word index out of range");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINAL) && !r_out_act) |=>
            ((r_pos == 6'd0) && (r_bits == 64'd0) && r_out_act))
        else $error("message state not cleared after the digest");

endmodule
